>>> rtl/pfg_pkg.sv
// Package for the particle push block: default parameters, register indexes,
// opcodes, state type; used by top level and testbench. No dependencies.
`timescale 1ns / 1ps
package pfg_pkg;
  localparam int NodesDefault = 256;
  localparam int PosFracBitsDefault = 24;

  localparam logic [1:0] RegAccelElectron = 2'd0;
  localparam logic [1:0] RegAccelIon      = 2'd1;
  localparam logic [1:0] RegHalfMassElec  = 2'd2;
  localparam logic [1:0] RegHalfMassIon   = 2'd3;

  localparam logic OpWrite = 1'b0;
  localparam logic OpPush  = 1'b1;

  typedef enum logic [3:0] {
    StIdle, StRead, StInterp, StAccel, StVel, StSq, StSum, StScaleLo, StScaleHi,
    StDone
  } state_e;
endpackage

>>> rtl/pic_field_gather_particle_push.sv
// Top level of the 1D particle push: field table memory, sequencer, one result
// register. Depends on pfg_pkg.
// A push runs through the sequencer steps (table reads, interpolation, velocity
// update, squares and energy scaling, one step per cycle) and no new item is taken
// until it is back in idle; a waiting result holds the sequencer in its last step,
// and field writes are taken every idle cycle.
// Reset clears control, configuration registers and both energy maxima; the field
// table is undefined until written.
`timescale 1ns / 1ps
module pic_field_gather_particle_push
  import pfg_pkg::*;
#(
  parameter int NODES = NodesDefault,
  parameter int POS_FRAC_BITS = PosFracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [7:0]         node_i,
  input  logic signed [31:0] field_value_i,
  input  logic [31:0]        position_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic               species_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        new_position_o,
  output logic signed [31:0] new_vel_x_o,
  output logic [63:0]        energy_o,
  output logic [63:0]        max_energy_o,
  output logic               out_of_range_o
);
  localparam int AW = $clog2(NODES);
  localparam int F = POS_FRAC_BITS;
  localparam logic [63:0] DomWide = 64'(NODES - 1) << F;
  localparam logic [31:0] Dom = (DomWide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : DomWide[31:0];
  localparam logic [AW-1:0] LastCell = AW'(NODES - 2);
  localparam logic [F:0] One = (F+1)'(1) << F;

  logic [31:0] mem_q [NODES];
  logic [31:0] rd_q;
  logic [AW-1:0] rd_addr;

  state_e state_q, state_d;
  logic signed [31:0] acc_e_q, acc_i_q;
  logic [31:0] hm_e_q, hm_i_q;
  logic [63:0] max_e_q, max_i_q;

  logic ion_q, flag_q;
  logic [31:0] pos_q, vx_in_q, vy_q, vz_q;
  logic [AW-1:0] cell_q;
  logic [F:0] frac_q;
  logic signed [31:0] left_q;
  logic signed [63:0] prod_l_q, prod_r_q;
  logic signed [31:0] fld_q;
  logic signed [63:0] dv_q;
  logic signed [31:0] vx_q;
  logic [63:0] sx_q, sy_q, sz_q, sum_q, lo_q, hi_q;

  logic [31:0] pos_res_q, vx_res_q;
  logic [63:0] en_res_q, max_res_q;
  logic flag_res_q, out_valid_q;

  // Datapath helpers.
  logic signed [40:0] vsum;
  logic signed [31:0] vx_sat;
  logic signed [36:0] dpos;
  logic signed [37:0] np;
  logic [63:0] en_c;
  logic [63:0] hi_sh;
  logic [64:0] en_sum;
  logic signed [63:0] fld_wide;

  logic in_fire;
  logic done_go;
  assign in_ready_o = (state_q == StIdle);
  assign in_fire = in_valid_i && in_ready_o;
  // The last step waits until the result register is free or being emptied.
  assign done_go = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // Front-end clamp and cell split.
  logic [31:0] pos_c;
  logic clamp_c;
  logic [31:0] cell_full;
  logic [AW-1:0] cell_c;
  always_comb begin
    clamp_c = position_i > Dom;
    pos_c = clamp_c ? Dom : position_i;
    cell_full = pos_c >> F;
    cell_c = (cell_full >= 32'(NODES - 1)) ? LastCell : cell_full[AW-1:0];
  end

  // Memory port: writes at idle; the left node is read at the accepting edge and
  // the right node in the cycle after.
  always_comb begin
    rd_addr = (state_q == StRead) ? AW'(cell_q + AW'(1)) : cell_c;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && opcode_i == OpWrite && 32'(node_i) < 32'(NODES)) begin
      mem_q[AW'(node_i)] <= field_value_i;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:    if (in_fire && opcode_i == OpPush) state_d = StRead;
      StRead:    state_d = StInterp;
      StInterp:  state_d = StAccel;
      StAccel:   state_d = StVel;
      StVel:     state_d = StSq;
      StSq:      state_d = StSum;
      StSum:     state_d = StScaleLo;
      StScaleLo: state_d = StScaleHi;
      StScaleHi: state_d = StDone;
      StDone:    if (!out_valid_q || out_ready_i) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      acc_e_q <= '0;
      acc_i_q <= '0;
      hm_e_q <= '0;
      hm_i_q <= '0;
      max_e_q <= '0;
      max_i_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegAccelElectron: acc_e_q <= cfg_data_i;
          RegAccelIon:      acc_i_q <= cfg_data_i;
          RegHalfMassElec:  hm_e_q <= cfg_data_i;
          RegHalfMassIon:   hm_i_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (done_go) begin
        out_valid_q <= 1'b1;
        if (ion_q) begin
          if (en_c > max_i_q) max_i_q <= en_c;
        end else begin
          if (en_c > max_e_q) max_e_q <= en_c;
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    vsum = 41'(signed'(vx_in_q)) + 41'(dv_q >>> 24);
    if (vsum > 41'sd2147483647) vx_sat = 32'sh7FFF_FFFF;
    else if (vsum < -41'sd2147483648) vx_sat = 32'sh8000_0000;
    else vx_sat = vsum[31:0];
    if (F >= 24) dpos = 37'(vx_q) <<< (F - 24);
    else dpos = 37'(vx_q) >>> (24 - F);
    np = 38'(signed'({1'b0, pos_q})) + 38'(dpos);
    fld_wide = (prod_l_q + prod_r_q) >>> F;
    hi_sh = hi_q << 8;
    en_sum = 65'(hi_sh) + 65'(lo_q >> 24);
    if (hi_q > (64'hFFFF_FFFF_FFFF_FFFF >> 8) || en_sum[64]) en_c = '1;
    else en_c = en_sum[63:0];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        ion_q <= species_i;
        flag_q <= clamp_c;
        pos_q <= pos_c;
        vx_in_q <= vel_x_i;
        vy_q <= vel_y_i;
        vz_q <= vel_z_i;
        cell_q <= cell_c;
        if (cell_full >= 32'(NODES - 1)) begin
          frac_q <= One;
        end else begin
          frac_q <= (F+1)'(pos_c & ((32'd1 << F) - 32'd1));
        end
      end
      StRead: left_q <= rd_q;
      StInterp: begin
        prod_l_q <= 64'(left_q) * 64'(signed'({1'b0, One - frac_q}));
        prod_r_q <= 64'(signed'(rd_q)) * 64'(signed'({1'b0, frac_q}));
      end
      StAccel: fld_q <= 32'(fld_wide);
      StVel: dv_q <= 64'(ion_q ? acc_i_q : acc_e_q) * 64'(fld_q);
      StSq: begin
        vx_q <= vx_sat;
        sy_q <= 64'(signed'(vy_q)) * 64'(signed'(vy_q));
        sz_q <= 64'(signed'(vz_q)) * 64'(signed'(vz_q));
      end
      StSum: begin
        sx_q <= 64'(vx_q) * 64'(vx_q);
        if (np < 0) begin
          pos_q <= '0;
          flag_q <= 1'b1;
        end else if (np > 38'(Dom)) begin
          pos_q <= Dom;
          flag_q <= 1'b1;
        end else begin
          pos_q <= np[31:0];
        end
      end
      StScaleLo: sum_q <= sx_q + sy_q + sz_q;
      StScaleHi: begin
        lo_q <= 64'(sum_q[31:0]) * 64'(ion_q ? hm_i_q : hm_e_q);
        hi_q <= 64'(sum_q[63:32]) * 64'(ion_q ? hm_i_q : hm_e_q);
      end
      StDone: begin
        if (done_go) begin
          pos_res_q <= pos_q;
          vx_res_q <= vx_q;
          en_res_q <= en_c;
          flag_res_q <= flag_q;
          if (ion_q) max_res_q <= (en_c > max_i_q) ? en_c : max_i_q;
          else max_res_q <= (en_c > max_e_q) ? en_c : max_e_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign new_position_o = pos_res_q;
  assign new_vel_x_o = vx_res_q;
  assign energy_o = en_res_q;
  assign max_energy_o = max_res_q;
  assign out_of_range_o = flag_res_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("accepted while busy");
  a_done_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_go |=> out_valid_q) else $error("result lost");
  a_push_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && opcode_i == OpPush) |=> (state_q == StRead)) else $error("push not started");
  a_max_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (max_e_q >= $past(max_e_q))) else $error("max decreased");
endmodule

>>> sim/tb_pic_field_gather_particle_push.sv
// Self-checking testbench for pic_field_gather_particle_push: directed and random
// field writes and particle pushes, checked against a built-in predictor. Depends on pfg_pkg.
`timescale 1ns / 1ps
module tb_pic_field_gather_particle_push
  import pfg_pkg::*;
();

  localparam longint ONE = longint'(1) << PosFracBitsDefault;
  localparam longint DOM = longint'(NodesDefault - 1) << PosFracBitsDefault;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         node;
    logic signed [31:0] field_value;
    logic [31:0]        position;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               species;
  } push_item_t;

  typedef struct packed {
    logic [31:0]        new_position;
    logic signed [31:0] new_vel_x;
    logic [63:0]        energy;
    logic [63:0]        max_energy;
    logic               out_of_range;
  } push_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic opcode_i;
  logic [7:0] node_i;
  logic signed [31:0] field_value_i, vel_x_i, vel_y_i, vel_z_i;
  logic [31:0] position_i;
  logic species_i;
  logic out_valid_o, out_ready_i;
  logic [31:0] new_position_o;
  logic signed [31:0] new_vel_x_o;
  logic [63:0] energy_o, max_energy_o;
  logic out_of_range_o;

  pic_field_gather_particle_push dut (.*);

  // Predictor state.
  logic signed [31:0] field_tab [NodesDefault];
  logic signed [31:0] accel_e, accel_i;
  logic [31:0] hmass_e, hmass_i;
  logic [63:0] peak_e, peak_i;

  push_result_t expected_pushes [$];
  int mismatches = 0;
  int pushes_checked = 0;
  int writes_sent = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  logic holding = 1'b0;
  event hold_kick;
  int cycles = 0;

  initial forever begin
    #1 clk_i = ~clk_i;
    if (clk_i) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial forever begin
    @(hold_kick);
    holding <= 1'b1;
    repeat (hold_len) @(posedge clk_i);
    holding <= 1'b0;
  end

  always @(posedge clk_i)
    out_ready_i <= !holding && ($urandom_range(99) >= recv_stall_pct);

  function automatic push_result_t push_particle(push_item_t it);
    push_result_t r;
    longint pos, cidx, frac, el, er, fld, acc, dv, vx, vy, vz, np;
    logic [63:0] sumsq;
    logic [127:0] prod;
    logic [31:0] scale;
    r.out_of_range = 1'b0;
    pos = longint'(it.position);
    if (pos > DOM) begin
      pos = DOM;
      r.out_of_range = 1'b1;
    end
    cidx = pos >> PosFracBitsDefault;
    frac = pos & (ONE - 1);
    // The last node lands in the last cell with all weight on its right end.
    if (cidx >= NodesDefault - 1) begin
      cidx = NodesDefault - 2;
      frac = ONE;
    end
    el = longint'(field_tab[cidx]);
    er = longint'(field_tab[cidx + 1]);
    fld = (el * (ONE - frac) + er * frac) >>> PosFracBitsDefault;
    acc = it.species ? longint'(accel_i) : longint'(accel_e);
    dv = (acc * fld) >>> 24;
    vx = longint'(it.vel_x) + dv;
    if (vx > 64'sd2147483647) vx = 64'sd2147483647;
    if (vx < -64'sd2147483648) vx = -64'sd2147483648;
    np = pos + vx;
    if (np < 0) begin
      np = 0;
      r.out_of_range = 1'b1;
    end else if (np > DOM) begin
      np = DOM;
      r.out_of_range = 1'b1;
    end
    vy = longint'(it.vel_y);
    vz = longint'(it.vel_z);
    sumsq = vx * vx + vy * vy + vz * vz;
    scale = it.species ? hmass_i : hmass_e;
    prod = (128'(scale) * 128'(sumsq)) >> 24;
    r.energy = (|prod[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
    if (it.species) begin
      if (r.energy > peak_i) peak_i = r.energy;
      r.max_energy = peak_i;
    end else begin
      if (r.energy > peak_e) peak_e = r.energy;
      r.max_energy = peak_e;
    end
    r.new_position = np[31:0];
    r.new_vel_x = vx[31:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    push_result_t exp_r, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{new_position_o, new_vel_x_o, energy_o, max_energy_o, out_of_range_o};
      if (expected_pushes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        exp_r = expected_pushes.pop_front();
        pushes_checked++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected pos=%h vx=%h e=%h max=%h oor=%b",
                     exp_r.new_position, exp_r.new_vel_x, exp_r.energy, exp_r.max_energy,
                     exp_r.out_of_range);
            $display("          got      pos=%h vx=%h e=%h max=%h oor=%b",
                     got.new_position, got.new_vel_x, got.energy, got.max_energy,
                     got.out_of_range);
          end
        end
      end
    end
  end

  // Called at a clock edge; returns at the edge where the transaction is accepted.
  task automatic send_item(push_item_t it);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= it.opcode;
    node_i <= it.node;
    field_value_i <= it.field_value;
    position_i <= it.position;
    vel_x_i <= it.vel_x;
    vel_y_i <= it.vel_y;
    vel_z_i <= it.vel_z;
    species_i <= it.species;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.opcode == OpPush) begin
      expected_pushes.push_back(push_particle(it));
    end else begin
      field_tab[it.node] = it.field_value;
      writes_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_pushes.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegAccelElectron: accel_e = data;
      RegAccelIon:      accel_i = data;
      RegHalfMassElec:  hmass_e = data;
      RegHalfMassIon:   hmass_i = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] ae, logic [31:0] ai, logic [31:0] he, logic [31:0] hi);
    write_reg(RegAccelElectron, ae);
    write_reg(RegAccelIon, ai);
    write_reg(RegHalfMassElec, he);
    write_reg(RegHalfMassIon, hi);
  endtask

  function automatic push_item_t make_push(logic [31:0] p, logic [31:0] vx, logic [31:0] vy,
                                           logic [31:0] vz, logic sp);
    push_item_t it;
    it = '{OpPush, 8'($urandom()), $urandom(), p, vx, vy, vz, sp};
    return it;
  endfunction

  function automatic push_item_t random_item();
    push_item_t it;
    int sel;
    it = '{OpPush, 8'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), 1'($urandom_range(1))};
    if ($urandom_range(99) < 12) begin
      it.opcode = OpWrite;
      return it;
    end
    sel = $urandom_range(9);
    // Mostly in-domain positions with modest velocities, plus full-range values.
    if (sel < 6) begin
      it.position = $urandom_range(32'hFF00_0000);
      it.vel_x = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
      it.vel_y = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
      it.vel_z = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
    end else if (sel == 6) begin
      it.position = 32'hFF00_0000 + $urandom_range(32'h00FF_FFFF);
    end
    return it;
  endfunction

  task automatic load_field_table();
    for (int n = 0; n < NodesDefault; n++)
      send_item('{OpWrite, 8'(n), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  1'($urandom_range(1))});
  endtask

  task automatic test_directed();
    push_item_t it;
    set_regs(32'h0100_0000, 32'hFFF0_0000, 32'd1, 32'd40);
    load_field_table();
    send_item('{OpWrite, 8'd0, 32'sh7FFF_FFFF, 32'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0});
    send_item('{OpWrite, 8'd1, -32'sh8000_0000, 32'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0});
    send_item('{OpWrite, 8'd255, 32'sh0123_4567, 32'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0});
    send_item(make_push(32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    send_item(make_push(32'h0080_0000, 32'h0100_0000, 32'h0, 32'h0, 1'b1));
    // Position exactly on the last node, then past the domain.
    send_item(make_push(32'hFF00_0000, 32'h0, 32'h0100_0000, 32'h0, 1'b0));
    send_item(make_push(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0100_0000, 1'b1));
    // Moves toward each end of the domain: the field turns the first back inside, the second leaves at the top.
    send_item(make_push(32'h0000_1000, 32'hF000_0000, 32'h0, 32'h0, 1'b0));
    send_item(make_push(32'hFE80_0000, 32'h0F00_0000, 32'h0, 32'h0, 1'b1));
    wait_drained();
    set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Velocity saturates both ways; energy saturates with extreme velocities.
    send_item(make_push(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    send_item(make_push(32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    send_item(make_push(32'h0100_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b0));
    send_item(make_push(32'hFF00_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    it = make_push(32'h7F00_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    send_item(it);
    wait_drained();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    wait_drained();
    set_regs($urandom() >>> $urandom_range(31), $urandom() >>> $urandom_range(31),
             $urandom() >> $urandom_range(31), $urandom() >> $urandom_range(31));
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) send_item(random_item());
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 300;
    -> hold_kick;
    for (int k = 0; k < 30; k++) send_item(random_item());
    // Sender waits here until every result has come back.
    wait_drained();
    for (int k = 0; k < 20; k++) send_item(random_item());
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= RegAccelElectron;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    opcode_i <= OpWrite;
    node_i <= '0;
    field_value_i <= '0;
    position_i <= '0;
    vel_x_i <= '0;
    vel_y_i <= '0;
    vel_z_i <= '0;
    species_i <= 1'b0;
    accel_e = '0;
    accel_i = '0;
    hmass_e = '0;
    hmass_i = '0;
    peak_e = '0;
    peak_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 125);
    test_random_phase(72, 0, 125);
    test_random_phase(0, 72, 125);
    test_random_phase(32, 32, 125);
    test_backpressure();
    wait_drained();
    set_regs(32'h0, 32'h0, 32'h0, 32'h0);
    send_item(make_push($urandom_range(32'hFF00_0000), $urandom(), $urandom(), $urandom(), 1'b0));
    wait_drained();
    $display("Covered %0d checked pushes and %0d field writes over idle, stall and hold phases.",
             pushes_checked, writes_sent);
    $display("Register settings included zero and both extremes; %0d mismatches.", mismatches);
    if (mismatches == 0 && expected_pushes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/pfg_pkg.sv
rtl/pic_field_gather_particle_push.sv
sim/tb_pic_field_gather_particle_push.sv
